>>> rtl/perlin_noise_3d_top_defines.svh
// Assertion macros used by the file that checks the noise pipeline.
`ifndef PERLIN_NOISE_3D_TOP_DEFINES_SVH
`define PERLIN_NOISE_3D_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PN3_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("noise pipeline check failed");

// Checks a property given whole, with its own implication and delays.
`define PN3_ASSERT_SEQ(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("noise pipeline timing check failed");

`endif

>>> rtl/pn3_pkg.sv
package pn3_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned TABLE_SIZE    = 256;
  localparam int unsigned IDX_W         = 8;
  localparam int unsigned COORD_W       = 24;
  localparam int unsigned OUT_W         = 18;
  localparam int unsigned LAT           = 13;

  localparam logic OP_EVAL = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic signed [63:0] OUT_MAX = 64'sd131071;
  localparam logic signed [63:0] OUT_MIN = -64'sd131072;

  // Shifts right by s with rounding to nearest, ties away from zero.
  function automatic logic signed [63:0] rnd_shift(logic signed [63:0] v, int unsigned s);
    logic [63:0] m;
    logic [63:0] r;
    if (s == 0) begin
      return v;
    end
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  // Gradient dot product selected by the low four hash bits.
  function automatic logic signed [31:0] grad(logic [3:0] h, logic signed [31:0] x,
                                              logic signed [31:0] y, logic signed [31:0] z);
    logic signed [31:0] u;
    logic signed [31:0] v;
    u = (h < 4'd8) ? x : y;
    v = (h < 4'd4) ? y : (((h == 4'd12) || (h == 4'd14)) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

endpackage

>>> rtl/pn3_ram.sv
module pn3_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [pn3_pkg::IDX_W-1:0]  waddr_i,
  input  logic [pn3_pkg::IDX_W-1:0]  wdata_i,
  input  logic [pn3_pkg::IDX_W-1:0]  raddr0_i,
  input  logic [pn3_pkg::IDX_W-1:0]  raddr1_i,
  output logic [pn3_pkg::IDX_W-1:0]  rdata0_o,
  output logic [pn3_pkg::IDX_W-1:0]  rdata1_o
);

  logic [pn3_pkg::IDX_W-1:0] mem_q [pn3_pkg::TABLE_SIZE];
  logic [pn3_pkg::IDX_W-1:0] rd0_q;
  logic [pn3_pkg::IDX_W-1:0] rd1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd0_q <= mem_q[raddr0_i];
    rd1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rd0_q;
  assign rdata1_o = rd1_q;

endmodule

>>> rtl/pn3_fade.sv
module pn3_fade #(
  parameter int unsigned FRAC_BITS = pn3_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic [FRAC_BITS-1:0] t_i,
  output logic [FRAC_BITS:0]   f_o
);

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned KW = F + 6;
  localparam int unsigned BW = F + 4;
  localparam int unsigned TW = F + 1;
  localparam logic [TW-1:0] ONE = TW'(1) << F;

  logic signed [KW-1:0]   ts;
  logic signed [KW-1:0]   k;
  logic signed [2*KW-1:0] m1_d, m1_q;
  logic [2*F-1:0]         m2_d, m2_q;
  logic [F-1:0]           t1_q, t2_q;
  logic [BW-1:0]          b2_d, b2_q, b3_q, b4_q;
  logic [TW-1:0]          sq2_d, sq2_q;
  logic [TW+F-1:0]        m3_d, m3_q;
  logic [TW-1:0]          t3_d, t3_q;
  logic [TW+BW-1:0]       m5_d, m5_q;
  logic signed [63:0]     f6;
  logic [TW-1:0]          f_d, f_q;

  assign ts   = signed'(KW'(t_i));
  assign k    = (ts <<< 2) + (ts <<< 1) - signed'(KW'(15) << F);
  assign m1_d = ts * k;
  assign m2_d = t_i * t_i;

  assign b2_d  = BW'(pn3_pkg::rnd_shift(64'(m1_q), F) + (64'sd10 <<< F));
  assign sq2_d = TW'(pn3_pkg::rnd_shift(64'(m2_q), F));

  assign m3_d = sq2_q * t2_q;
  assign t3_d = TW'(pn3_pkg::rnd_shift(64'(m3_q), F));
  assign m5_d = t3_q * b4_q;

  assign f6  = pn3_pkg::rnd_shift(64'(m5_q), F);
  assign f_d = (f6 > 64'(ONE)) ? ONE : TW'(f6);

  always_ff @(posedge clk_i) begin
    m1_q  <= m1_d;
    m2_q  <= m2_d;
    t1_q  <= t_i;
    b2_q  <= b2_d;
    sq2_q <= sq2_d;
    t2_q  <= t1_q;
    m3_q  <= m3_d;
    b3_q  <= b2_q;
    t3_q  <= t3_d;
    b4_q  <= b3_q;
    m5_q  <= m5_d;
    f_q   <= f_d;
  end

  assign f_o = f_q;

endmodule

>>> rtl/perlin_noise_3d_top.sv
// Channel   Direction  Handshake              Payload
// request   in         start_i while !busy_o  op_i, coord_x_i, coord_y_i, coord_z_i,
//                                             load_index_i, load_value_i
// result    out        valid_o, one cycle     noise_o
//
// A new request is taken in every cycle; busy_o is never raised.
// An evaluate request gives its result once it has passed the three dependent table
// lookups, the fade multiplier chain and three lerp levels.
// A load request writes each table copy as it passes that copy's stage and gives
// no result. Reset clears the valid bits only; the table holds no reset value.
`include "perlin_noise_3d_top_defines.svh"

module perlin_noise_3d_top #(
  parameter int unsigned FRAC_BITS = pn3_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             op_i,
  input  logic [pn3_pkg::COORD_W-1:0]      coord_x_i,
  input  logic [pn3_pkg::COORD_W-1:0]      coord_y_i,
  input  logic [pn3_pkg::COORD_W-1:0]      coord_z_i,
  input  logic [pn3_pkg::IDX_W-1:0]        load_index_i,
  input  logic [pn3_pkg::IDX_W-1:0]        load_value_i,
  output logic                             valid_o,
  output logic signed [pn3_pkg::OUT_W-1:0] noise_o
);

  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned IW  = pn3_pkg::IDX_W;
  localparam int unsigned LAT = pn3_pkg::LAT;
  localparam int unsigned GW  = F + 2;
  localparam int unsigned DW  = F + 3;
  localparam int unsigned UW  = F + 1;
  localparam int unsigned PW  = DW + UW + 1;

  logic            acc;
  logic [LAT-1:0]  ev_q;
  logic            ld1_q, ld2_q;

  logic [31:0]     cxe, cye, cze;
  logic [IW-1:0]   cx, cy, cz;

  logic [IW-1:0]   y1_q, z1_q, z2_q;
  logic [IW-1:0]   li1_q, lv1_q, li2_q, lv2_q;
  logic [F-1:0]    fr1_q [3];
  logic [F-1:0]    fr2_q [3];
  logic [F-1:0]    fr3_q [3];

  logic [IW-1:0]   p1_rd [2];
  logic [IW-1:0]   p2_rd [2][2];
  logic [IW-1:0]   p3_rd [4][2];

  logic [F:0]      fade6 [3];

  logic signed [GW-1:0] g_d  [8];
  logic signed [GW-1:0] g4_q [8];
  logic signed [GW-1:0] g5_q [8];
  logic signed [GW-1:0] g6_q [8];

  logic signed [PW-1:0] pr7_q [4];
  logic signed [GW-1:0] a7_q  [4];
  logic signed [GW-1:0] l8_q  [4];
  logic signed [PW-1:0] pr9_q [2];
  logic signed [GW-1:0] a9_q  [2];
  logic signed [GW-1:0] l10_q [2];
  logic signed [PW-1:0] pr11_q;
  logic signed [GW-1:0] a11_q;
  logic signed [GW-1:0] r12_q;

  logic [F:0] fv7_q, fw7_q, fv8_q, fw8_q, fw9_q, fw10_q;

  logic signed [63:0]               sc;
  logic signed [pn3_pkg::OUT_W-1:0] noise_d, noise_q;

  assign busy_o = 1'b0;
  assign acc    = start_i && !busy_o;

  assign cxe = {8'b0, coord_x_i};
  assign cye = {8'b0, coord_y_i};
  assign cze = {8'b0, coord_z_i};
  assign cx  = cxe[F +: IW];
  assign cy  = cye[F +: IW];
  assign cz  = cze[F +: IW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q  <= '0;
      ld1_q <= 1'b0;
      ld2_q <= 1'b0;
    end else begin
      ev_q  <= {ev_q[LAT-2:0], acc && (op_i == pn3_pkg::OP_EVAL)};
      ld1_q <= acc && (op_i == pn3_pkg::OP_LOAD);
      ld2_q <= ld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    y1_q     <= cy;
    z1_q     <= cz;
    z2_q     <= z1_q;
    li1_q    <= load_index_i;
    lv1_q    <= load_value_i;
    li2_q    <= li1_q;
    lv2_q    <= lv1_q;
    fr1_q[0] <= coord_x_i[F-1:0];
    fr1_q[1] <= coord_y_i[F-1:0];
    fr1_q[2] <= coord_z_i[F-1:0];
    fr2_q    <= fr1_q;
    fr3_q    <= fr2_q;
  end

  pn3_ram u_ram1 (
    .clk_i    (clk_i),
    .we_i     (acc && (op_i == pn3_pkg::OP_LOAD)),
    .waddr_i  (load_index_i),
    .wdata_i  (load_value_i),
    .raddr0_i (cx),
    .raddr1_i (cx + IW'(1)),
    .rdata0_o (p1_rd[0]),
    .rdata1_o (p1_rd[1])
  );

  for (genvar j = 0; j < 2; j++) begin : g_ram2
    pn3_ram u_ram (
      .clk_i    (clk_i),
      .we_i     (ld1_q),
      .waddr_i  (li1_q),
      .wdata_i  (lv1_q),
      .raddr0_i (p1_rd[j] + y1_q),
      .raddr1_i (p1_rd[j] + y1_q + IW'(1)),
      .rdata0_o (p2_rd[j][0]),
      .rdata1_o (p2_rd[j][1])
    );
  end

  for (genvar r = 0; r < 4; r++) begin : g_ram3
    pn3_ram u_ram (
      .clk_i    (clk_i),
      .we_i     (ld2_q),
      .waddr_i  (li2_q),
      .wdata_i  (lv2_q),
      .raddr0_i (p2_rd[r % 2][r / 2] + z2_q),
      .raddr1_i (p2_rd[r % 2][r / 2] + z2_q + IW'(1)),
      .rdata0_o (p3_rd[r][0]),
      .rdata1_o (p3_rd[r][1])
    );
  end

  for (genvar c = 0; c < 3; c++) begin : g_fade
    pn3_fade #(.FRAC_BITS(FRAC_BITS)) u_fade (
      .clk_i (clk_i),
      .t_i   (c == 0 ? coord_x_i[F-1:0] : (c == 1 ? coord_y_i[F-1:0] : coord_z_i[F-1:0])),
      .f_o   (fade6[c])
    );
  end

  for (genvar i = 0; i < 8; i++) begin : g_grad
    logic signed [31:0] px, py, pz;
    assign px = ((i % 2) == 1) ? 32'(fr3_q[0]) - (32'sd1 <<< F) : 32'(fr3_q[0]);
    assign py = (((i / 2) % 2) == 1) ? 32'(fr3_q[1]) - (32'sd1 <<< F) : 32'(fr3_q[1]);
    assign pz = (i >= 4) ? 32'(fr3_q[2]) - (32'sd1 <<< F) : 32'(fr3_q[2]);
    assign g_d[i] = GW'(pn3_pkg::grad(p3_rd[i % 4][i / 4][3:0], px, py, pz));
  end

  always_ff @(posedge clk_i) begin
    g4_q <= g_d;
    g5_q <= g4_q;
    g6_q <= g5_q;
    fv7_q <= fade6[1];
    fw7_q <= fade6[2];
    for (int j = 0; j < 4; j++) begin
      a7_q[j]  <= g6_q[2*j];
      pr7_q[j] <= (DW'(g6_q[2*j+1]) - DW'(g6_q[2*j])) * $signed({1'b0, fade6[0]});
      l8_q[j]  <= GW'(64'(a7_q[j]) + pn3_pkg::rnd_shift(64'(pr7_q[j]), F));
    end
    fv8_q <= fv7_q;
    fw8_q <= fw7_q;
    for (int k = 0; k < 2; k++) begin
      a9_q[k]  <= l8_q[2*k];
      pr9_q[k] <= (DW'(l8_q[2*k+1]) - DW'(l8_q[2*k])) * $signed({1'b0, fv8_q});
      l10_q[k] <= GW'(64'(a9_q[k]) + pn3_pkg::rnd_shift(64'(pr9_q[k]), F));
    end
    fw9_q  <= fw8_q;
    fw10_q <= fw9_q;
    a11_q  <= l10_q[0];
    pr11_q <= (DW'(l10_q[1]) - DW'(l10_q[0])) * $signed({1'b0, fw10_q});
    r12_q  <= GW'(64'(a11_q) + pn3_pkg::rnd_shift(64'(pr11_q), F));
    noise_q <= noise_d;
  end

  if (F >= 16) begin : g_scale_down
    assign sc = pn3_pkg::rnd_shift(64'(r12_q), F - 16);
  end else begin : g_scale_up
    assign sc = 64'(r12_q) <<< (16 - F);
  end

  always_comb begin
    if (sc > pn3_pkg::OUT_MAX) begin
      noise_d = pn3_pkg::OUT_W'(pn3_pkg::OUT_MAX);
    end else if (sc < pn3_pkg::OUT_MIN) begin
      noise_d = pn3_pkg::OUT_W'(pn3_pkg::OUT_MIN);
    end else begin
      noise_d = pn3_pkg::OUT_W'(sc);
    end
  end

  assign valid_o = ev_q[LAT-1];
  assign noise_o = noise_q;

  `PN3_ASSERT_IMP(a_result_has_request, clk_i, rst_ni, valid_o, $past(acc && (op_i == pn3_pkg::OP_EVAL), LAT))
  `PN3_ASSERT_SEQ(a_request_gives_result, clk_i, rst_ni, ((acc && (op_i == pn3_pkg::OP_EVAL)) |-> ##13 valid_o))
  `PN3_ASSERT_IMP(a_load_not_eval, clk_i, rst_ni, ld2_q, !ev_q[1])

endmodule

>>> dv/perlin_noise_3d_top_tb.sv
module perlin_noise_3d_top_tb;

  localparam int  FRAC    = pn3_pkg::FRAC_BITS_DEF;
  localparam longint ONE  = longint'(1) << FRAC;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             start_i;
  logic                             busy_o;
  logic                             op_i;
  logic [pn3_pkg::COORD_W-1:0]      coord_x_i;
  logic [pn3_pkg::COORD_W-1:0]      coord_y_i;
  logic [pn3_pkg::COORD_W-1:0]      coord_z_i;
  logic [pn3_pkg::IDX_W-1:0]        load_index_i;
  logic [pn3_pkg::IDX_W-1:0]        load_value_i;
  logic                             valid_o;
  logic signed [pn3_pkg::OUT_W-1:0] noise_o;

  logic [7:0]                       perm_shadow [pn3_pkg::TABLE_SIZE];
  logic signed [pn3_pkg::OUT_W-1:0] noise_expected [$];
  int                               error_count;

  perlin_noise_3d_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o), .op_i(op_i),
    .coord_x_i(coord_x_i), .coord_y_i(coord_y_i), .coord_z_i(coord_z_i),
    .load_index_i(load_index_i), .load_value_i(load_value_i),
    .valid_o(valid_o), .noise_o(noise_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic longint round_shr(longint v, int s);
    longint mag;
    longint r;
    mag = (v < 0) ? -v : v;
    r = (mag + (longint'(1) << (s - 1))) >>> s;
    return (v < 0) ? -r : r;
  endfunction

  function automatic longint mul_fx(longint a, longint b);
    return round_shr(a * b, FRAC);
  endfunction

  function automatic longint quintic_fade(longint t);
    longint b;
    longint t3;
    longint f;
    b = mul_fx(t, 6 * t - 15 * ONE) + 10 * ONE;
    t3 = mul_fx(mul_fx(t, t), t);
    f = mul_fx(t3, b);
    if (f < 0) f = 0;
    if (f > ONE) f = ONE;
    return f;
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return a + mul_fx(b - a, t);
  endfunction

  function automatic longint corner_dot(logic [7:0] hash, longint x, longint y, longint z);
    logic [3:0] h;
    longint     u;
    longint     v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [7:0] perm_at(int i);
    return perm_shadow[i & 255];
  endfunction

  function automatic logic signed [pn3_pkg::OUT_W-1:0] noise_at(
      logic [pn3_pkg::COORD_W-1:0] cx,
      logic [pn3_pkg::COORD_W-1:0] cy,
      logic [pn3_pkg::COORD_W-1:0] cz);
    int     gx, gy, gz, a, b, aa, ab, ba, bb;
    longint x, y, z, x1, y1, z1, u, v, w, l0, l1, r;
    gx = int'(cx[23:16]);
    gy = int'(cy[23:16]);
    gz = int'(cz[23:16]);
    x = longint'(cx[15:0]);
    y = longint'(cy[15:0]);
    z = longint'(cz[15:0]);
    x1 = x - ONE;
    y1 = y - ONE;
    z1 = z - ONE;
    u = quintic_fade(x);
    v = quintic_fade(y);
    w = quintic_fade(z);
    a = int'(perm_at(gx)) + gy;
    b = int'(perm_at(gx + 1)) + gy;
    aa = int'(perm_at(a)) + gz;
    ab = int'(perm_at(a + 1)) + gz;
    ba = int'(perm_at(b)) + gz;
    bb = int'(perm_at(b + 1)) + gz;
    l0 = blend(blend(corner_dot(perm_at(aa), x, y, z), corner_dot(perm_at(ba), x1, y, z), u),
               blend(corner_dot(perm_at(ab), x, y1, z), corner_dot(perm_at(bb), x1, y1, z), u),
               v);
    l1 = blend(blend(corner_dot(perm_at(aa + 1), x, y, z1),
                     corner_dot(perm_at(ba + 1), x1, y, z1), u),
               blend(corner_dot(perm_at(ab + 1), x, y1, z1),
                     corner_dot(perm_at(bb + 1), x1, y1, z1), u), v);
    r = blend(l0, l1, w);
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[pn3_pkg::OUT_W-1:0];
  endfunction

  // Drives one request and holds start high until it is taken.
  task automatic send_request(logic op, logic [pn3_pkg::COORD_W-1:0] x,
                              logic [pn3_pkg::COORD_W-1:0] y,
                              logic [pn3_pkg::COORD_W-1:0] z, logic [7:0] idx,
                              logic [7:0] val);
    start_i <= 1'b1;
    op_i <= op;
    coord_x_i <= x;
    coord_y_i <= y;
    coord_z_i <= z;
    load_index_i <= idx;
    load_value_i <= val;
    do @(posedge clk_i); while (busy_o);
    if (op == pn3_pkg::OP_LOAD) begin
      perm_shadow[idx] = val;
    end else begin
      noise_expected.push_back(noise_at(x, y, z));
    end
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic send_eval(logic [pn3_pkg::COORD_W-1:0] x, logic [pn3_pkg::COORD_W-1:0] y,
                           logic [pn3_pkg::COORD_W-1:0] z);
    send_request(pn3_pkg::OP_EVAL, x, y, z, 8'($urandom), 8'($urandom));
  endtask

  task automatic send_load(logic [7:0] idx, logic [7:0] val);
    send_request(pn3_pkg::OP_LOAD, 24'($urandom), 24'($urandom), 24'($urandom), idx, val);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (noise_expected.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_table_fill();
    logic [7:0] order [pn3_pkg::TABLE_SIZE];
    logic [7:0] tmp;
    int         j;
    for (int i = 0; i < pn3_pkg::TABLE_SIZE; i++) order[i] = 8'(i);
    for (int i = pn3_pkg::TABLE_SIZE - 1; i > 0; i--) begin
      j = int'($urandom_range(i, 0));
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < pn3_pkg::TABLE_SIZE; i++) send_load(8'(i), order[i]);
  endtask

  task automatic test_corners();
    send_eval(24'h000000, 24'h000000, 24'h000000);
    send_eval(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_eval(24'hFF0000, 24'hFF0000, 24'hFF0000);
    send_eval(24'h00FFFF, 24'h00FFFF, 24'h00FFFF);
    send_eval(24'h008000, 24'h008000, 24'h008000);
    send_eval(24'hFF8000, 24'h000001, 24'h7F4000);
    send_eval(24'h123456, 24'hABCDEF, 24'hFEDCBA);
    send_eval(24'h00FFFF, 24'h000000, 24'hFFFFFF);
    // Entries holding 255 at both ends of the table push hash indices past the wrap.
    send_load(8'd255, 8'd255);
    send_load(8'd0, 8'd255);
    send_eval(24'hFF7FFF, 24'hFFC000, 24'hFF2000);
    send_eval(24'hFE0001, 24'hFFFFFE, 24'h01FFFF);
    wait_drained();
  endtask

  task automatic test_random_stream();
    int burst;
    for (int n = 0; n < 1030; ) begin
      burst = int'($urandom_range(40, 1));
      for (int k = 0; k < burst; k++, n++) begin
        if ($urandom_range(99, 0) < 12) send_load(8'($urandom), 8'($urandom));
        else send_eval(24'($urandom), 24'($urandom), 24'($urandom));
      end
      if (n > 500 && n < 550) wait_drained();
      else if ($urandom_range(3, 0) != 0) pause_sender(int'($urandom_range(6, 1)));
    end
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (noise_expected.size() == 0) begin
        $display("%0t: unexpected noise result, actual %0d", $time, noise_o);
        error_count++;
      end else begin
        if (noise_o !== noise_expected[0]) begin
          $display("%0t: noise mismatch, expected %0d, actual %0d",
                   $time, noise_expected[0], noise_o);
          error_count++;
        end
        void'(noise_expected.pop_front());
      end
    end
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    error_count = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    op_i = pn3_pkg::OP_EVAL;
    coord_x_i = '0;
    coord_y_i = '0;
    coord_z_i = '0;
    load_index_i = '0;
    load_value_i = '0;
    for (int i = 0; i < pn3_pkg::TABLE_SIZE; i++) perm_shadow[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_fill();
    test_corners();
    test_random_stream();
    repeat (pn3_pkg::LAT + 10) @(posedge clk_i);
    if (error_count == 0 && noise_expected.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
